>>> rtl/core/set_associative_cache_tag_lru_defines.svh
// Assertion macros used by the checker of the cache tag store.
// No dependencies; include with the bare file name.
`ifndef SET_ASSOCIATIVE_CACHE_TAG_LRU_DEFINES_SVH
`define SET_ASSOCIATIVE_CACHE_TAG_LRU_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CSTL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CSTL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/cstl_pkg.sv
// Types and constants of the set-associative cache tag store.
// No dependencies; used by every module of the block.
package cstl_pkg;

   localparam int ADDR_WIDTH   = 32;
   localparam int MAX_WAYS     = 8;
   localparam int MAX_SET_BITS = 8;
   localparam int NUM_SETS     = 1 << MAX_SET_BITS;
   localparam int SET_BITS     = MAX_SET_BITS;
   localparam int WAY_BITS     = 3;
   localparam int NWAY_BITS    = 4;
   localparam int LRU_BITS     = 4;
   localparam int TAG_BITS     = ADDR_WIDTH;
   localparam int CSR_DATA_BITS = 5;

   localparam logic [4:0] OFFSET_BITS_RESET = 5'd5;
   localparam logic [3:0] INDEX_BITS_RESET  = 4'd6;
   localparam logic [3:0] NUM_WAYS_RESET    = 4'd4;
   localparam logic       USE_LRU_RESET     = 1'b1;

   typedef enum logic [1:0] {
      CSR_OFFSET_BITS = 2'd0,
      CSR_INDEX_BITS  = 2'd1,
      CSR_NUM_WAYS    = 2'd2,
      CSR_USE_LRU     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] address;
      logic [2:0]            random_way;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] way;
   } rsp_type;

   // One set's valid bits and LRU counters, kept as one memory row.
   typedef struct packed {
      logic [MAX_WAYS-1:0]               valid;
      logic [MAX_WAYS-1:0][LRU_BITS-1:0] lru;
   } meta_type;

   typedef logic [MAX_WAYS-1:0][TAG_BITS-1:0] tag_row_type;

   // Outcome of one lookup, handed from the update logic to the top level.
   typedef struct packed {
      logic                hit;
      logic [WAY_BITS-1:0] way;
      meta_type            meta;
   } upd_type;

   localparam meta_type META_RESET = '{valid: '0, lru: {MAX_WAYS{LRU_BITS'(1)}}};

endpackage

>>> rtl/core/set_associative_cache_tag_lru.sv
// Set-associative cache tag store with counter LRU or random replacement.
// Each request's set row is read into registers, then its result is registered;
// a stalled earlier result holds the lookup. Requests do not overlap: req_stall
// stays high through the read-modify-write of the set's row in the tag and
// valid/LRU memories. Reset: synchronous; a sweep then clears the valid/LRU
// memory while req_stall stays high. Configuration writes are taken at any time.
module set_associative_cache_tag_lru
   import cstl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   state_type            state_ff, state_in;
   logic [4:0]           offset_ff;
   logic [3:0]           index_ff;
   logic [NWAY_BITS-1:0] nways_ff;
   logic                 use_lru_ff;

   logic [TAG_BITS-1:0]  tag_ff;
   logic [SET_BITS-1:0]  set_ff;
   logic [2:0]           rnd_ff;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 req_fire;
   logic                 lk_go;
   logic [3:0]           ib_eff;
   logic [SET_BITS:0]    set_span;
   logic [SET_BITS-1:0]  set_mask;
   logic [SET_BITS-1:0]  set_idx;
   logic [5:0]           tag_shift;
   logic [TAG_BITS-1:0]  tag_val;
   logic [NWAY_BITS-1:0] nways_eff;
   logic                 meta_clearing;
   meta_type             meta_rd;
   tag_row_type          tag_rd;
   upd_type              upd;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign lk_go     = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   // Address split: index width clamped to the set count, shifts past the
   // top of the address give zero.
   always_comb begin
      ib_eff    = (index_ff > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : index_ff;
      set_span  = ((SET_BITS + 1)'(1) << ib_eff) - (SET_BITS + 1)'(1);
      set_mask  = set_span[SET_BITS-1:0];
      set_idx   = SET_BITS'(req_payload.address >> offset_ff) & set_mask;
      tag_shift = 6'(offset_ff) + 6'(ib_eff);
      tag_val   = TAG_BITS'(req_payload.address >> tag_shift);
      if (nways_ff == '0) begin
         nways_eff = NWAY_BITS'(1);
      end else if (nways_ff > NWAY_BITS'(MAX_WAYS)) begin
         nways_eff = NWAY_BITS'(MAX_WAYS);
      end else begin
         nways_eff = nways_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (!meta_clearing) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (lk_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (lk_go) begin
         rsp_in.hit   = upd.hit;
         rsp_in.way   = upd.way;
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         offset_ff    <= OFFSET_BITS_RESET;
         index_ff     <= INDEX_BITS_RESET;
         nways_ff     <= NUM_WAYS_RESET;
         use_lru_ff   <= USE_LRU_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_OFFSET_BITS: offset_ff  <= csr_wdata[4:0];
               CSR_INDEX_BITS:  index_ff   <= csr_wdata[3:0];
               CSR_NUM_WAYS:    nways_ff   <= csr_wdata[NWAY_BITS-1:0];
               CSR_USE_LRU:     use_lru_ff <= csr_wdata[0];
               default:         use_lru_ff <= use_lru_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_fire) begin
         tag_ff <= tag_val;
         set_ff <= set_idx;
         rnd_ff <= req_payload.random_way;
      end
   end

   cstl_meta_store u_meta (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_fire),
      .rd_addr  (set_idx),
      .rd_data  (meta_rd),
      .wr_en    (lk_go),
      .wr_addr  (set_ff),
      .wr_data  (upd.meta),
      .clearing (meta_clearing)
   );

   cstl_tag_store u_tags (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (set_idx),
      .rd_data (tag_rd),
      .wr_en   (lk_go && !upd.hit),
      .wr_addr (set_ff),
      .wr_way  (upd.way),
      .wr_tag  (tag_ff)
   );

   cstl_update u_update (
      .meta    (meta_rd),
      .tags    (tag_rd),
      .tag     (tag_ff),
      .rnd     (rnd_ff),
      .nways   (nways_eff),
      .use_lru (use_lru_ff),
      .upd     (upd)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/core/cstl_meta_store.sv
// Valid bits and LRU counters of all sets, one row per set.
// Depends on cstl_pkg; runs a clearing sweep after reset.
module cstl_meta_store
   import cstl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [SET_BITS-1:0] rd_addr,
   output meta_type            rd_data,
   input  logic                wr_en,
   input  logic [SET_BITS-1:0] wr_addr,
   input  meta_type            wr_data,
   output logic                clearing
);

   meta_type            mem [NUM_SETS];
   meta_type            rd_data_ff;
   logic [SET_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic                clearing_ff, clearing_in;

   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + SET_BITS'(1);
         if (clr_cnt_ff == '1) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clearing_ff <= clearing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_cnt_ff] <= META_RESET;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

>>> rtl/core/cstl_tag_store.sv
// Tag memory, one row of all ways per set; writes replace a single way
// of the row last read. Depends on cstl_pkg.
module cstl_tag_store
   import cstl_pkg::*;
(
   input  logic                clock,
   input  logic                rd_en,
   input  logic [SET_BITS-1:0] rd_addr,
   output tag_row_type         rd_data,
   input  logic                wr_en,
   input  logic [SET_BITS-1:0] wr_addr,
   input  logic [WAY_BITS-1:0] wr_way,
   input  logic [TAG_BITS-1:0] wr_tag
);

   tag_row_type mem [NUM_SETS];
   tag_row_type rd_data_ff;
   tag_row_type merged;

   // The held read data is the row of the set being written, so the other
   // ways are carried over unchanged.
   always_comb begin
      merged         = rd_data_ff;
      merged[wr_way] = wr_tag;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= merged;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/cstl_update.sv
// Hit search, victim choice and LRU counter update for one set.
// Depends on cstl_pkg; purely combinational.
module cstl_update
   import cstl_pkg::*;
(
   input  meta_type             meta,
   input  tag_row_type          tags,
   input  logic [TAG_BITS-1:0]  tag,
   input  logic [2:0]           rnd,
   input  logic [NWAY_BITS-1:0] nways,
   input  logic                 use_lru,
   output upd_type              upd
);

   logic [MAX_WAYS-1:0] in_use;
   logic [MAX_WAYS-1:0] match;
   logic [MAX_WAYS-1:0] free;
   logic                hit;
   logic                any_free;
   logic [WAY_BITS-1:0] hit_way;
   logic [WAY_BITS-1:0] free_way;
   logic [WAY_BITS-1:0] lru_way;
   logic [WAY_BITS-1:0] rnd_way;
   logic [WAY_BITS-1:0] sel;
   logic [LRU_BITS-1:0] mine;
   meta_type            meta_new;

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w] = NWAY_BITS'(w) < nways;
         match[w]  = in_use[w] && meta.valid[w] && (tags[w] == tag);
         free[w]   = in_use[w] && !meta.valid[w];
      end

      hit      = 1'b0;
      any_free = 1'b0;
      hit_way  = '0;
      free_way = '0;
      // Downward scan so that the lowest matching or free way wins.
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit     = 1'b1;
            hit_way = WAY_BITS'(w);
         end
         if (free[w]) begin
            any_free = 1'b1;
            free_way = WAY_BITS'(w);
         end
      end

      // Smallest counter, lowest way on ties.
      lru_way = '0;
      for (int w = 1; w < MAX_WAYS; w++) begin
         if (in_use[w] && (meta.lru[w] < meta.lru[lru_way])) begin
            lru_way = WAY_BITS'(w);
         end
      end

      if ({1'b0, rnd} < nways) begin
         rnd_way = rnd;
      end else begin
         rnd_way = WAY_BITS'(nways - NWAY_BITS'(1));
      end

      if (hit) begin
         sel = hit_way;
      end else if (any_free) begin
         sel = free_way;
      end else if (use_lru) begin
         sel = lru_way;
      end else begin
         sel = rnd_way;
      end

      meta_new            = meta;
      meta_new.valid[sel] = 1'b1;
      mine                = meta.lru[sel];
      if (use_lru) begin
         for (int j = 0; j < MAX_WAYS; j++) begin
            if (in_use[j] && (WAY_BITS'(j) != sel) && meta.valid[j] &&
                (meta.lru[j] > mine)) begin
               meta_new.lru[j] = meta.lru[j] - LRU_BITS'(1);
            end
         end
         meta_new.lru[sel] = LRU_BITS'(nways);
      end

      upd.hit  = hit;
      upd.way  = sel;
      upd.meta = meta_new;
   end

endmodule

>>> rtl/core/cstl_checker.sv
// Port-level checks of the cache tag store, bound to the top level.
// Depends on cstl_pkg and the assertion macros header.
`include "set_associative_cache_tag_lru_defines.svh"

module cstl_checker
   import cstl_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   logic req_beat;
   logic rsp_held;

   assign req_beat = req_valid && !req_stall;
   assign rsp_held = rsp_valid && rsp_stall;

   // A stalled result beat stays offered.
   `CSTL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid, "result beat dropped")
   // A stalled result beat keeps its payload.
   `CSTL_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_held, $stable(rsp_payload), "rsp changed")
   // Each request beat is followed by a stall, while the set's row is written back.
   `CSTL_ASSERT_NEXT(a_req_gap, clock, reset, req_beat, req_stall, "back-to-back requests")
   // A fresh result beat must directly follow a request beat and its lookup state.
   `CSTL_ASSERT_SAME(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(req_beat, 2), "no request")

endmodule

bind set_associative_cache_tag_lru cstl_checker u_cstl_checker (.*);
